// ===== rtl/tpsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsg_pkg: shared types and constants of the touch position filter
// Request payloads, register map, microcode word layout and filter tables.
// ----------------------------------------------------------------------------
package tpsg_pkg;

  // window and value widths
  localparam int WINDOW_LEN = 15;
  localparam int TAP_W      = $clog2(WINDOW_LEN);
  localparam int POS_W      = 24;
  localparam int RAW_W      = 12;
  localparam int LEN_W      = 16;
  localparam int PROD_W     = RAW_W + 1 + LEN_W + 1;
  localparam int SMOOTH_W   = 35;
  localparam int RATE_W     = 30;
  localparam int DIV_W      = 36;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

  // filter denominators
  localparam int SMOOTH_DEN  = 1105;
  localparam int RATE_DEN    = 280;
  localparam int SMOOTH_HALF = SMOOTH_DEN / 2;
  localparam int RATE_HALF   = RATE_DEN / 2;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_X_MAX = 3'd0;
  localparam logic [2:0] REG_X_MIN = 3'd1;
  localparam logic [2:0] REG_X_LEN = 3'd2;
  localparam logic [2:0] REG_Y_MAX = 3'd3;
  localparam logic [2:0] REG_Y_MIN = 3'd4;
  localparam logic [2:0] REG_Y_LEN = 3'd5;

  localparam logic [RAW_W-1:0] X_MAX_RST = 12'd3900;
  localparam logic [RAW_W-1:0] X_MIN_RST = 12'd130;
  localparam logic [LEN_W-1:0] X_LEN_RST = 16'd45192;
  localparam logic [RAW_W-1:0] Y_MAX_RST = 12'd3900;
  localparam logic [RAW_W-1:0] Y_MIN_RST = 12'd252;
  localparam logic [LEN_W-1:0] Y_LEN_RST = 16'd34658;

  // request payloads
  typedef struct packed {
    logic             touched;
    logic [RAW_W-1:0] x_raw;
    logic [RAW_W-1:0] y_raw;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_smooth;
    logic signed [POS_W-1:0] x_rate;
    logic signed [POS_W-1:0] y_smooth;
    logic signed [POS_W-1:0] y_rate;
  } result_t;

  // microcode operations
  localparam int PC_W = 5;
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_WAIT_IN   = 4'd1;
  localparam logic [3:0] OP_MAP       = 4'd2;
  localparam logic [3:0] OP_DIV_START = 4'd3;
  localparam logic [3:0] OP_DIV_WAIT  = 4'd4;
  localparam logic [3:0] OP_STORE     = 4'd5;
  localparam logic [3:0] OP_PUSH      = 4'd6;
  localparam logic [3:0] OP_MAC       = 4'd7;
  localparam logic [3:0] OP_OUT       = 4'd8;

  // operand / destination selects
  localparam logic [2:0] SEL_X_MAP    = 3'd0;
  localparam logic [2:0] SEL_Y_MAP    = 3'd1;
  localparam logic [2:0] SEL_X_SMOOTH = 3'd2;
  localparam logic [2:0] SEL_X_RATE   = 3'd3;
  localparam logic [2:0] SEL_Y_SMOOTH = 3'd4;
  localparam logic [2:0] SEL_Y_RATE   = 3'd5;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      sel;
    logic            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, sel: SEL_X_MAP, jmp: 1'b1, target: '0};
    unique case (pc)
      5'd0:  w = '{op: OP_WAIT_IN,   sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd1:  w = '{op: OP_MAP,       sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd2:  w = '{op: OP_DIV_START, sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd3:  w = '{op: OP_DIV_WAIT,  sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd4:  w = '{op: OP_STORE,     sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd5:  w = '{op: OP_MAP,       sel: SEL_Y_MAP,    jmp: 1'b0, target: '0};
      5'd6:  w = '{op: OP_DIV_START, sel: SEL_Y_MAP,    jmp: 1'b0, target: '0};
      5'd7:  w = '{op: OP_DIV_WAIT,  sel: SEL_Y_MAP,    jmp: 1'b0, target: '0};
      5'd8:  w = '{op: OP_STORE,     sel: SEL_Y_MAP,    jmp: 1'b0, target: '0};
      5'd9:  w = '{op: OP_PUSH,      sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd10: w = '{op: OP_MAC,       sel: SEL_X_MAP,    jmp: 1'b0, target: '0};
      5'd11: w = '{op: OP_DIV_START, sel: SEL_X_SMOOTH, jmp: 1'b0, target: '0};
      5'd12: w = '{op: OP_DIV_WAIT,  sel: SEL_X_SMOOTH, jmp: 1'b0, target: '0};
      5'd13: w = '{op: OP_STORE,     sel: SEL_X_SMOOTH, jmp: 1'b0, target: '0};
      5'd14: w = '{op: OP_DIV_START, sel: SEL_X_RATE,   jmp: 1'b0, target: '0};
      5'd15: w = '{op: OP_DIV_WAIT,  sel: SEL_X_RATE,   jmp: 1'b0, target: '0};
      5'd16: w = '{op: OP_STORE,     sel: SEL_X_RATE,   jmp: 1'b0, target: '0};
      5'd17: w = '{op: OP_DIV_START, sel: SEL_Y_SMOOTH, jmp: 1'b0, target: '0};
      5'd18: w = '{op: OP_DIV_WAIT,  sel: SEL_Y_SMOOTH, jmp: 1'b0, target: '0};
      5'd19: w = '{op: OP_STORE,     sel: SEL_Y_SMOOTH, jmp: 1'b0, target: '0};
      5'd20: w = '{op: OP_DIV_START, sel: SEL_Y_RATE,   jmp: 1'b0, target: '0};
      5'd21: w = '{op: OP_DIV_WAIT,  sel: SEL_Y_RATE,   jmp: 1'b0, target: '0};
      5'd22: w = '{op: OP_STORE,     sel: SEL_Y_RATE,   jmp: 1'b0, target: '0};
      5'd23: w = '{op: OP_OUT,       sel: SEL_X_MAP,    jmp: 1'b1, target: '0};
      default: w = '{op: OP_NOP,     sel: SEL_X_MAP,    jmp: 1'b1, target: '0};
    endcase
    return w;
  endfunction

  // smoothing numerators, quadratic 15-point
  function automatic logic signed [8:0] smooth_coef(input logic [TAP_W-1:0] k);
    logic signed [8:0] c;
    c = '0;
    unique case (k)
      4'd0, 4'd14: c = -9'sd78;
      4'd1, 4'd13: c = -9'sd13;
      4'd2, 4'd12: c = 9'sd42;
      4'd3, 4'd11: c = 9'sd87;
      4'd4, 4'd10: c = 9'sd122;
      4'd5, 4'd9:  c = 9'sd147;
      4'd6, 4'd8:  c = 9'sd162;
      4'd7:        c = 9'sd167;
      default:     c = '0;
    endcase
    return c;
  endfunction

  // derivative numerators: tap position relative to the center
  function automatic logic signed [3:0] rate_coef(input logic [TAP_W-1:0] k);
    logic [TAP_W:0] d;
    d = {1'b0, k} - (TAP_W + 1)'(WINDOW_LEN / 2);
    return d[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/touch_position_sg_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// touch_position_sg_filter_unit: touch position mapping and smoothing
// Maps raw panel readings to Q8 mm, keeps a 15-sample window per axis and
// returns the Savitzky-Golay smoothed position and first derivative.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall sample_t (touched, x_raw, y_raw)
//  result    out        result_valid/result_stall result_t (smooth, rate per axis)
//  config    in         apb psel/penable/pwrite   six calibration registers
//
//  a request runs from accept to loaded result through two mapping divisions,
//  the window push, a 15-tap accumulation and four filter divisions on the
//  shared two-bit-per-cycle divider; the next one is taken once it is loaded.
//  rst (synchronous) restores calibration defaults and clears both windows.
//  the result register holds a finished request while the next one runs; the
//  sequencer waits at its output step only if that register is still stalled.
// ----------------------------------------------------------------------------
module touch_position_sg_filter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        sample_valid,
  output      logic                        sample_stall,
  input  wire tpsg_pkg::sample_t           sample,
  output      logic                        result_valid,
  input  wire logic                        result_stall,
  output      tpsg_pkg::result_t           result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tpsg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);
  import tpsg_pkg::*;

  // calibration registers
  logic [RAW_W-1:0] x_max, x_min, y_max, y_min;
  logic [LEN_W-1:0] x_len, y_len;

  // sequencer
  logic [PC_W-1:0] pc, pc_next;
  ucode_t          uc;
  logic            hold;

  // latched request
  logic             in_touched;
  logic [RAW_W-1:0] in_x, in_y;

  // mapping datapath
  logic signed [PROD_W-1:0] prod;
  logic [RAW_W-1:0]         span;
  logic                     deg;
  logic [RAW_W-1:0]         m_raw, m_max, m_min, m_span;
  logic [LEN_W-1:0]         m_len;
  logic signed [RAW_W:0]    m_diff;

  // windows and accumulators
  logic signed [POS_W-1:0]    x_win [WINDOW_LEN];
  logic signed [POS_W-1:0]    y_win [WINDOW_LEN];
  logic signed [POS_W-1:0]    x_pos, y_pos;
  logic [TAP_W-1:0]           tap;
  logic signed [SMOOTH_W-1:0] acc_xs, acc_ys;
  logic signed [RATE_W-1:0]   acc_xr, acc_yr;
  logic signed [32:0]         mul_xs, mul_ys;
  logic signed [27:0]         mul_xr, mul_yr;

  // divider
  logic [DIV_W-1:0]    div_num;
  logic [RAW_W-1:0]    div_rem, div_den;
  logic                div_neg;
  logic [DCNT_W-1:0]   div_cnt;
  logic [RAW_W:0]      r1, r2;
  logic                q1, q2;
  logic [RAW_W-1:0]    r1s, r2s;
  logic signed [DIV_W-1:0] op_sum;
  logic [DIV_W-1:0]    op_mag;
  logic [RAW_W-1:0]    op_half, op_den;
  logic signed [POS_W-1:0] div_val;

  // staged outputs
  logic signed [POS_W-1:0] x_smooth, x_rate, y_smooth, y_rate;

  logic cfg_wr;

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign uc           = ucode_rom(pc);
  assign sample_stall = (uc.op != OP_WAIT_IN);

  // register read mux
  always_comb begin
    unique case (paddr[4:2])
      REG_X_MAX: prdata = 32'(x_max);
      REG_X_MIN: prdata = 32'(x_min);
      REG_X_LEN: prdata = 32'(x_len);
      REG_Y_MAX: prdata = 32'(y_max);
      REG_Y_MIN: prdata = 32'(y_min);
      REG_Y_LEN: prdata = 32'(y_len);
      default:   prdata = '0;
    endcase
  end

  // step hold conditions and next step
  always_comb begin
    unique case (uc.op)
      OP_WAIT_IN:  hold = !sample_valid;
      OP_DIV_WAIT: hold = (div_cnt != '0);
      OP_MAC:      hold = (tap != TAP_W'(WINDOW_LEN - 1));
      OP_OUT:      hold = result_valid && result_stall;
      default:     hold = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (uc.jmp) begin
      pc_next = uc.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // axis select and offset for the mapping multiply
  always_comb begin
    if (uc.sel == SEL_Y_MAP) begin
      m_raw = in_y;
      m_max = y_max;
      m_min = y_min;
      m_len = y_len;
    end else begin
      m_raw = in_x;
      m_max = x_max;
      m_min = x_min;
      m_len = x_len;
    end
    m_span = m_max - m_min;
    m_diff = $signed({1'b0, m_raw}) - $signed({2'b00, m_span[RAW_W-1:1]});
  end

  // tap products
  assign mul_xs = x_win[0] * smooth_coef(tap);
  assign mul_ys = y_win[0] * smooth_coef(tap);
  assign mul_xr = x_win[0] * rate_coef(tap);
  assign mul_yr = y_win[0] * rate_coef(tap);

  // divider operand select: sign, magnitude, rounding offset, divisor
  always_comb begin
    unique case (uc.sel)
      SEL_X_SMOOTH: begin
        op_sum  = DIV_W'(acc_xs);
        op_half = RAW_W'(SMOOTH_HALF);
        op_den  = RAW_W'(SMOOTH_DEN);
      end
      SEL_Y_SMOOTH: begin
        op_sum  = DIV_W'(acc_ys);
        op_half = RAW_W'(SMOOTH_HALF);
        op_den  = RAW_W'(SMOOTH_DEN);
      end
      SEL_X_RATE: begin
        op_sum  = DIV_W'(acc_xr);
        op_half = RAW_W'(RATE_HALF);
        op_den  = RAW_W'(RATE_DEN);
      end
      SEL_Y_RATE: begin
        op_sum  = DIV_W'(acc_yr);
        op_half = RAW_W'(RATE_HALF);
        op_den  = RAW_W'(RATE_DEN);
      end
      default: begin
        op_sum  = DIV_W'(prod);
        op_half = '0;
        op_den  = span;
      end
    endcase
    op_mag = op_sum[DIV_W-1] ? DIV_W'(-op_sum) : DIV_W'(op_sum);
  end

  // two restoring division steps per cycle
  always_comb begin
    r1  = {div_rem, div_num[DIV_W-1]};
    q1  = (r1 >= {1'b0, div_den});
    r1s = q1 ? RAW_W'(r1 - {1'b0, div_den}) : r1[RAW_W-1:0];
    r2  = {r1s, div_num[DIV_W-2]};
    q2  = (r2 >= {1'b0, div_den});
    r2s = q2 ? RAW_W'(r2 - {1'b0, div_den}) : r2[RAW_W-1:0];
  end

  // signed, saturated quotient
  always_comb begin
    if (div_neg) begin
      if (div_num > DIV_W'(24'h800000)) begin
        div_val = POS_MIN;
      end else begin
        div_val = POS_W'(~div_num[POS_W-1:0] + POS_W'(1));
      end
    end else begin
      if (div_num > DIV_W'(POS_MAX)) begin
        div_val = POS_MAX;
      end else begin
        div_val = div_num[POS_W-1:0];
      end
    end
  end

  // control state, configuration and windows
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= '0;
      result_valid <= 1'b0;
      div_cnt      <= '0;
      x_max        <= X_MAX_RST;
      x_min        <= X_MIN_RST;
      x_len        <= X_LEN_RST;
      y_max        <= Y_MAX_RST;
      y_min        <= Y_MIN_RST;
      y_len        <= Y_LEN_RST;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        x_win[i] <= '0;
        y_win[i] <= '0;
      end
    end else begin
      pc <= pc_next;

      // configuration writes
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_X_MAX: x_max <= pwdata[RAW_W-1:0];
          REG_X_MIN: x_min <= pwdata[RAW_W-1:0];
          REG_X_LEN: x_len <= pwdata[LEN_W-1:0];
          REG_Y_MAX: y_max <= pwdata[RAW_W-1:0];
          REG_Y_MIN: y_min <= pwdata[RAW_W-1:0];
          REG_Y_LEN: y_len <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end

      // result register
      if (uc.op == OP_OUT && !hold) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      // divider count
      if (uc.op == OP_DIV_START) begin
        div_cnt <= DCNT_W'(DIV_STEPS);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - DCNT_W'(1);
      end

      // push new position (only when touched), or rotate one tap during accumulation
      if (uc.op == OP_PUSH) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          x_win[i] <= x_win[i+1];
          y_win[i] <= y_win[i+1];
        end
        if (in_touched) begin
          x_win[WINDOW_LEN-1] <= x_pos;
          y_win[WINDOW_LEN-1] <= y_pos;
        end
      end else if (uc.op == OP_MAC) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          x_win[i] <= x_win[i+1];
          y_win[i] <= y_win[i+1];
        end
        x_win[WINDOW_LEN-1] <= x_win[0];
        y_win[WINDOW_LEN-1] <= y_win[0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // latch the request
    if (uc.op == OP_WAIT_IN && sample_valid) begin
      in_touched <= sample.touched;
      in_x       <= sample.x_raw;
      in_y       <= sample.y_raw;
    end

    // mapping multiply
    if (uc.op == OP_MAP) begin
      deg  <= (m_max <= m_min);
      span <= m_span;
      prod <= m_diff * $signed({1'b0, m_len});
    end

    // divider load and iterate
    if (uc.op == OP_DIV_START) begin
      div_num <= op_mag + DIV_W'(op_half);
      div_rem <= '0;
      div_den <= op_den;
      div_neg <= op_sum[DIV_W-1];
    end else if (div_cnt != '0) begin
      div_num <= {div_num[DIV_W-3:0], q1, q2};
      div_rem <= r2s;
    end

    // accumulators: clear at push, one tap per cycle after
    if (uc.op == OP_PUSH) begin
      tap    <= '0;
      acc_xs <= '0;
      acc_ys <= '0;
      acc_xr <= '0;
      acc_yr <= '0;
    end else if (uc.op == OP_MAC) begin
      tap    <= tap + TAP_W'(1);
      acc_xs <= acc_xs + SMOOTH_W'(mul_xs);
      acc_ys <= acc_ys + SMOOTH_W'(mul_ys);
      acc_xr <= acc_xr + RATE_W'(mul_xr);
      acc_yr <= acc_yr + RATE_W'(mul_yr);
    end

    // store quotients
    if (uc.op == OP_STORE) begin
      unique case (uc.sel)
        SEL_X_MAP:    x_pos    <= deg ? '0 : div_val;
        SEL_Y_MAP:    y_pos    <= deg ? '0 : div_val;
        SEL_X_SMOOTH: x_smooth <= div_val;
        SEL_X_RATE:   x_rate   <= div_val;
        SEL_Y_SMOOTH: y_smooth <= div_val;
        SEL_Y_RATE:   y_rate   <= div_val;
        default: ;
      endcase
    end

    // load the result register
    if (uc.op == OP_OUT && !hold) begin
      result.x_smooth <= x_smooth;
      result.x_rate   <= x_rate;
      result.y_smooth <= y_smooth;
      result.y_rate   <= y_rate;
    end
  end

endmodule
`default_nettype wire
